// ===== rtl/core/least_connections_balancer_macros.svh =====
// Assertion macros used by the balancer controller.
`ifndef LEAST_CONNECTIONS_BALANCER_MACROS_SVH
`define LEAST_CONNECTIONS_BALANCER_MACROS_SVH

// Check a same-cycle implication, clocked on clk_i, off during reset.
`define LCB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a next-cycle implication, clocked on clk_i, off during reset.
`define LCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lcb_pkg.sv =====
// Shared types, widths and codes of the least-connections balancer.
package lcb_pkg;

  localparam int MaxBackendsDefault = 16;
  localparam int CountBitsDefault   = 16;

  localparam int OpW      = 2;
  localparam int IdxW     = 4;
  localparam int CntOutW  = 16;
  localparam int RunW     = 8;
  localparam int BcW      = 5;
  localparam int ThrW     = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  localparam logic [RunW-1:0] RunMax       = '1;
  localparam logic [BcW-1:0]  BcReset      = 5'd16;
  localparam logic [ThrW-1:0] HealthyThr   = 8'd2;
  localparam logic [ThrW-1:0] UnhealthyThr = 8'd3;

  typedef enum logic [OpW-1:0] {
    OP_SELECT  = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PROBE   = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BACKEND_COUNT       = 2'd0,
    CFG_HEALTHY_THRESHOLD   = 2'd1,
    CFG_UNHEALTHY_THRESHOLD = 2'd2
  } cfg_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic start;
    logic scan_rd;
    logic scan_cmp;
    logic op_rd;
    logic sel_wr;
    logic op_wr;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic req_select;
    logic scan_more;
  } stat_t;

  typedef struct packed {
    logic               granted;
    logic [IdxW-1:0]    chosen_backend;
    logic [CntOutW-1:0] connection_count;
    logic               backend_healthy;
    logic               health_changed;
  } rsp_t;

endpackage

// ===== rtl/core/lcb_ifs.sv =====
// Request, result and configuration channel interfaces of the balancer.
interface lcb_req_if;
  logic                       valid;
  logic                       ready;
  logic [lcb_pkg::OpW-1:0]    opcode;
  logic [lcb_pkg::IdxW-1:0]   backend_index;
  logic                       probe_ok;

  modport source (output valid, opcode, backend_index, probe_ok, input ready);
  modport sink   (input valid, opcode, backend_index, probe_ok, output ready);
endinterface

interface lcb_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        granted;
  logic [lcb_pkg::IdxW-1:0]    chosen_backend;
  logic [lcb_pkg::CntOutW-1:0] connection_count;
  logic                        backend_healthy;
  logic                        health_changed;

  modport source (output valid, granted, chosen_backend, connection_count,
                  backend_healthy, health_changed, input ready);
  modport sink   (input valid, granted, chosen_backend, connection_count,
                  backend_healthy, health_changed, output ready);
endinterface

interface lcb_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lcb_pkg::CfgIdxW-1:0]  index;
  logic [lcb_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/lcb_datapath.sv =====
// Balancer datapath: registers, backend table memory, scan and update logic.
module lcb_datapath #(
  parameter int MAX_BACKENDS = lcb_pkg::MaxBackendsDefault,
  parameter int COUNT_BITS   = lcb_pkg::CountBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lcb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lcb_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [lcb_pkg::OpW-1:0]      opcode_i,
  input  logic [lcb_pkg::IdxW-1:0]     backend_index_i,
  input  logic                         probe_ok_i,
  input  lcb_pkg::cmd_t                cmd_i,
  output lcb_pkg::stat_t               stat_o,
  output lcb_pkg::rsp_t                rsp_o
);
  import lcb_pkg::*;

  localparam int AW = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
  localparam int NW = $clog2(MAX_BACKENDS + 1);
  localparam int CW = (NW > BcW) ? NW : BcW;
  localparam int RW = (NW > IdxW) ? NW : IdxW;

  typedef struct packed {
    logic [COUNT_BITS-1:0] cnt;
    logic [RunW-1:0]       succ;
    logic [RunW-1:0]       fail;
  } word_t;

  // Configuration registers.
  logic [BcW-1:0]  bc_q;
  logic [ThrW-1:0] hthr_q, uthr_q;

  // Captured request.
  op_e             op_q;
  logic [IdxW-1:0] idx_q;
  logic            ok_q;

  // Backend table: memory plus per-entry written flags and health flags.
  word_t                   mem [MAX_BACKENDS];
  logic [MAX_BACKENDS-1:0] valid_q;
  logic [MAX_BACKENDS-1:0] health_q;

  logic          rd_en;
  logic [AW-1:0] rd_addr, rd_addr_q;
  word_t         rd_data_q, rd_word;
  logic          rd_health;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  word_t         wr_data;
  logic          h_we, h_val;

  // Scan state.
  logic [NW-1:0] ptr_q;
  logic [AW-1:0] best_q;
  word_t         best_word_q;
  logic          found_q;

  logic [NW-1:0] n_use;
  logic          in_range;
  rsp_t          rsp_d, rsp_q;

  always_comb begin
    if (CW'(bc_q) > CW'(MAX_BACKENDS)) begin
      n_use = NW'(MAX_BACKENDS);
    end else begin
      n_use = NW'(bc_q);
    end
  end

  assign in_range          = RW'(idx_q) < RW'(n_use);
  assign stat_o.req_select = (opcode_i == OP_SELECT);
  assign stat_o.scan_more  = ptr_q < n_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q   <= BcReset;
      hthr_q <= HealthyThr;
      uthr_q <= UnhealthyThr;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_index_i))
        CFG_BACKEND_COUNT:       bc_q   <= BcW'(cfg_data_i);
        CFG_HEALTHY_THRESHOLD:   hthr_q <= cfg_data_i;
        CFG_UNHEALTHY_THRESHOLD: uthr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= op_e'(opcode_i);
      idx_q <= backend_index_i;
      ok_q  <= probe_ok_i;
    end
  end

  // Table read port.
  assign rd_en   = cmd_i.scan_rd | cmd_i.op_rd;
  assign rd_addr = cmd_i.scan_rd ? ptr_q[AW-1:0] : AW'(idx_q);

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  assign rd_word   = valid_q[rd_addr_q] ? rd_data_q : '0;
  assign rd_health = health_q[rd_addr_q];

  // Table write port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      health_q <= '1;
    end else begin
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (h_we) begin
        health_q[wr_addr] <= h_val;
      end
    end
  end

  // Least-count scan, one entry per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        ptr_q   <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.scan_rd) begin
        ptr_q <= ptr_q + NW'(1);
      end
      if (cmd_i.scan_cmp && rd_health && (!found_q || rd_word.cnt < best_word_q.cnt)) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_cmp && rd_health && (!found_q || rd_word.cnt < best_word_q.cnt)) begin
      best_q      <= rd_addr_q;
      best_word_q <= rd_word;
    end
  end

  // Update and result formation.
  always_comb begin
    word_t           w;
    logic [RunW-1:0] run_new;
    w       = rd_word;
    run_new = '0;
    wr_en   = 1'b0;
    wr_addr = best_q;
    wr_data = best_word_q;
    h_we    = 1'b0;
    h_val   = 1'b0;
    rsp_d   = '0;
    if (cmd_i.sel_wr) begin
      if (found_q) begin
        wr_en = 1'b1;
        if (best_word_q.cnt != '1) begin
          wr_data.cnt = best_word_q.cnt + COUNT_BITS'(1);
        end
        rsp_d.granted          = 1'b1;
        rsp_d.chosen_backend   = IdxW'(best_q);
        rsp_d.connection_count = CntOutW'(wr_data.cnt);
        rsp_d.backend_healthy  = 1'b1;
      end
    end else if (cmd_i.op_wr) begin
      wr_addr              = rd_addr_q;
      wr_data              = w;
      rsp_d.chosen_backend = idx_q;
      if (in_range) begin
        rsp_d.backend_healthy = rd_health;
        case (op_q)
          OP_RELEASE: begin
            wr_en = 1'b1;
            if (w.cnt != '0) begin
              wr_data.cnt = w.cnt - COUNT_BITS'(1);
            end
          end
          OP_PROBE: begin
            wr_en = 1'b1;
            if (ok_q) begin
              run_new      = (w.succ == RunMax) ? w.succ : w.succ + RunW'(1);
              wr_data.succ = run_new;
              wr_data.fail = '0;
              if (!rd_health && run_new >= hthr_q) begin
                h_we                 = 1'b1;
                h_val                = 1'b1;
                rsp_d.health_changed = 1'b1;
                rsp_d.backend_healthy = 1'b1;
              end
            end else begin
              run_new      = (w.fail == RunMax) ? w.fail : w.fail + RunW'(1);
              wr_data.fail = run_new;
              wr_data.succ = '0;
              if (rd_health && run_new >= uthr_q) begin
                h_we                 = 1'b1;
                h_val                = 1'b0;
                rsp_d.health_changed = 1'b1;
                rsp_d.backend_healthy = 1'b0;
              end
            end
          end
          default: ;
        endcase
        rsp_d.connection_count = CntOutW'(wr_data.cnt);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel_wr || cmd_i.op_wr) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ===== rtl/core/lcb_ctrl.sv =====
// Balancer controller: sequences accept, scan, update and result hand-off.
`include "least_connections_balancer_macros.svh"

module lcb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  input  lcb_pkg::stat_t stat_i,
  output lcb_pkg::cmd_t  cmd_o
);
  import lcb_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_SEL_WR = 5'b00100,
    ST_OP_RD  = 5'b01000,
    ST_OP_WR  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   cmp_pend_q;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = stat_i.req_select ? ST_SCAN : ST_OP_RD;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_cmp = cmp_pend_q;
        if (stat_i.scan_more) begin
          cmd_o.scan_rd = 1'b1;
        end else begin
          state_d = ST_SEL_WR;
        end
      end
      ST_SEL_WR: begin
        if (slot_free) begin
          cmd_o.sel_wr = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_OP_RD: begin
        cmd_o.op_rd = 1'b1;
        state_d     = ST_OP_WR;
      end
      ST_OP_WR: begin
        if (slot_free) begin
          cmd_o.op_wr = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.sel_wr || cmd_o.op_wr) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmp_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmp_pend_q  <= cmd_o.scan_rd;
      out_valid_q <= out_valid_d;
    end
  end

  `LCB_ASSERT_NEXT(a_busy_after_accept, req_valid_i && req_ready_o, !req_ready_o, "request taken while busy")
  `LCB_ASSERT_NOW(a_no_result_overwrite, cmd_o.sel_wr || cmd_o.op_wr, !out_valid_q || rsp_ready_i, "pending result overwritten")
  `LCB_ASSERT_NOW(a_cmp_follows_read, cmd_o.scan_cmp, $past(cmd_o.scan_rd), "compare without a preceding read")

endmodule

// ===== rtl/core/least_connections_balancer.sv =====
// Top level of the least-connections load balancer with health hysteresis.
// Channels: req_i (opcode, backend_index, probe_ok) and rsp_o (granted,
// chosen_backend, connection_count, backend_healthy, health_changed) are
// valid/ready streams; a beat moves when valid and ready are both high.
// cfg_i writes one register per beat: index 0 backend_count, 1 healthy
// threshold, 2 unhealthy threshold; it is always ready. Write it only idle.
// Every request beat yields exactly one result beat, in order.
// A select scans the backends in use one per cycle through the single read
// port of the backend table, then updates the chosen entry, if any, and
// registers the result. Release and probe read the addressed entry, then
// update it when in range and register the result. One request is in
// flight at a time; a new request is taken once the previous one has left
// its result in the output register, even if the receiver has not taken it.
// Receiver stall: the result holds in the output register; a later request
// finishes its work and then waits until that register frees up.
// Reset: all counts and run counters read as zero, all backends healthy,
// registers at 16 / 2 / 3. Per-entry written flags stand in for clearing
// the table, so there is no clearing pass and the block is ready at once.
module least_connections_balancer #(
  parameter int MAX_BACKENDS = lcb_pkg::MaxBackendsDefault,
  parameter int COUNT_BITS   = lcb_pkg::CountBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  lcb_req_if.sink   req_i,
  lcb_rsp_if.source rsp_o,
  lcb_cfg_if.sink   cfg_i
);
  import lcb_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  rsp_t  rsp;

  // Configuration writes are taken every cycle.
  assign cfg_i.ready = 1'b1;

  lcb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lcb_datapath #(
    .MAX_BACKENDS (MAX_BACKENDS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .opcode_i        (req_i.opcode),
    .backend_index_i (req_i.backend_index),
    .probe_ok_i      (req_i.probe_ok),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .rsp_o           (rsp)
  );

  // Drive the result beat from the output register.
  assign rsp_o.granted          = rsp.granted;
  assign rsp_o.chosen_backend   = rsp.chosen_backend;
  assign rsp_o.connection_count = rsp.connection_count;
  assign rsp_o.backend_healthy  = rsp.backend_healthy;
  assign rsp_o.health_changed   = rsp.health_changed;

endmodule
